[hw/rtl/site_stats_hash_table_defines.svh]
// Assertion macros for the site statistics hash table.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SITE_STATS_HASH_TABLE_DEFINES_SVH
`define SITE_STATS_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define SSHT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SSHT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SSHT_ASSERT(name, prop, msg)
`define SSHT_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[hw/rtl/ssht_pkg.sv]
// Shared types, constants and helper functions of the site statistics hash table.
// No dependencies; used by ssht_alu and site_stats_hash_table.
package ssht_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int KEY_W         = 48;
   localparam int LINE_W        = 32;
   localparam int BYTES_W       = 48;
   localparam int COUNT_W       = 32;
   localparam int FUNC_W        = 2;
   localparam int SLOT_OUT_W    = 8;

   localparam logic [LINE_W-1:0] HASH_MUL = 32'h9E37_79B1;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GROW  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

   typedef enum logic [1:0] {
      STAT_HIT,
      STAT_NEW,
      STAT_FULL,
      STAT_IGNORED
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD_SAT,
      ALU_SUB_FLOOR,
      ALU_MAX
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PROBE,
      ST_ACCUM,
      ST_LIVE,
      ST_PEAK,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LINE_W-1:0]  line;
      logic [BYTES_W-1:0] allocated;
      logic [BYTES_W-1:0] freed;
      logic [BYTES_W-1:0] live;
      logic [BYTES_W-1:0] peak;
      logic [COUNT_W-1:0] allocs;
      logic [COUNT_W-1:0] grows;
      logic [COUNT_W-1:0] frees;
   } entry_type;

   typedef struct packed {
      logic                  strobe;
      status_type            status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [BYTES_W-1:0]    allocated;
      logic [BYTES_W-1:0]    freed;
      logic [BYTES_W-1:0]    live;
      logic [BYTES_W-1:0]    peak;
      logic [COUNT_W-1:0]    allocs;
      logic [COUNT_W-1:0]    grows;
      logic [COUNT_W-1:0]    frees;
      logic                  overflow;
   } rsp_type;

   function automatic logic [COUNT_W-1:0] inc_sat(input logic [COUNT_W-1:0] count);
      return (count == '1) ? count : count + COUNT_W'(1);
   endfunction

   // The reported slot carries the full table index, since SLOT_OUT_W equals SLOT_W.
   function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] slot);
      logic [15:0] wide;
      wide = 16'(slot);
      return wide[SLOT_OUT_W-1:0];
   endfunction

endpackage

[hw/rtl/ssht_alu.sv]
// Shared 48-bit byte-counter unit: saturating add, subtract with floor at zero, maximum.
// Depends on ssht_pkg.
module ssht_alu (
   input  ssht_pkg::alu_op_type            op,
   input  logic [ssht_pkg::BYTES_W-1:0]    a,
   input  logic [ssht_pkg::BYTES_W-1:0]    b,
   output logic [ssht_pkg::BYTES_W-1:0]    y
);

   logic                        sub;
   logic [ssht_pkg::BYTES_W:0]  sum;

   // One adder serves all operations; for a subtraction the carry out means a >= b.
   assign sub = (op != ssht_pkg::ALU_ADD_SAT);
   assign sum = {1'b0, a} + {1'b0, b ^ {ssht_pkg::BYTES_W{sub}}}
                + (ssht_pkg::BYTES_W + 1)'(sub);

   always_comb begin
      unique case (op)
         ssht_pkg::ALU_ADD_SAT: begin
            y = sum[ssht_pkg::BYTES_W] ? '1 : sum[ssht_pkg::BYTES_W-1:0];
         end
         ssht_pkg::ALU_SUB_FLOOR: begin
            y = sum[ssht_pkg::BYTES_W] ? sum[ssht_pkg::BYTES_W-1:0] : '0;
         end
         ssht_pkg::ALU_MAX: begin
            y = sum[ssht_pkg::BYTES_W] ? a : b;
         end
         default: begin
            y = a;
         end
      endcase
   end

endmodule

[hw/rtl/site_stats_hash_table.sv]
// An ignored request answers on the cycle after it is taken. Otherwise each probe is a
// registered table read (ST_READ) then a compare (ST_PROBE). A free then passes ST_ACCUM,
// ST_LIVE and ST_WRITE, an allocation or growth also ST_PEAK before ST_WRITE. A full table
// answers from ST_PROBE after its last probe. The update uses the shared byte unit in
// ST_ACCUM, ST_LIVE and ST_PEAK. busy is low again in the cycle that carries the strobe.
// Reset empties the table at once through per-slot valid bits and clears the overflow flag.
`include "site_stats_hash_table_defines.svh"
module site_stats_hash_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ssht_pkg::FUNC_W-1:0]       req_func,
   input  logic [ssht_pkg::KEY_W-1:0]        req_site_key,
   input  logic [ssht_pkg::LINE_W-1:0]       req_line_number,
   input  logic [ssht_pkg::BYTES_W-1:0]      req_size_bytes,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [ssht_pkg::SLOT_OUT_W-1:0]   rsp_slot_index,
   output logic [ssht_pkg::BYTES_W-1:0]      rsp_site_total_allocated,
   output logic [ssht_pkg::BYTES_W-1:0]      rsp_site_total_freed,
   output logic [ssht_pkg::BYTES_W-1:0]      rsp_site_current_usage,
   output logic [ssht_pkg::BYTES_W-1:0]      rsp_site_peak_usage,
   output logic [ssht_pkg::COUNT_W-1:0]      rsp_site_alloc_count,
   output logic [ssht_pkg::COUNT_W-1:0]      rsp_site_grow_count,
   output logic [ssht_pkg::COUNT_W-1:0]      rsp_site_free_count,
   output logic                              rsp_overflow_seen
);

   localparam logic [ssht_pkg::SLOT_W-1:0] LAST_PROBE = ssht_pkg::SLOT_W'(ssht_pkg::TABLE_ENTRIES - 1);

   ssht_pkg::state_type                state_ff, state_in;
   logic [ssht_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [ssht_pkg::SLOT_W-1:0]        probe_cnt_ff, probe_cnt_in;
   ssht_pkg::entry_type                entry_ff, entry_in;
   logic                               new_ff, new_in;
   logic                               overflow_ff, overflow_in;
   logic [ssht_pkg::FUNC_W-1:0]        func_ff, func_in;
   logic [ssht_pkg::KEY_W-1:0]         key_ff, key_in;
   logic [ssht_pkg::LINE_W-1:0]        line_ff, line_in;
   logic [ssht_pkg::BYTES_W-1:0]       size_ff, size_in;
   ssht_pkg::rsp_type                  rsp_ff, rsp_in;

   ssht_pkg::entry_type                table_mem [ssht_pkg::TABLE_ENTRIES];
   logic [ssht_pkg::TABLE_ENTRIES-1:0] valid_ff;
   ssht_pkg::entry_type                rd_data_ff;
   logic                               rd_valid_ff;
   logic                               mem_we;

   ssht_pkg::alu_op_type               alu_op;
   logic [ssht_pkg::BYTES_W-1:0]       alu_a, alu_b, alu_y;

   ssht_pkg::entry_type                probe_entry;
   logic                               probe_hit, probe_empty, is_free, req_ignored;
   logic [ssht_pkg::SLOT_W-1:0]        home_slot;

   ssht_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // Only the low slot bits of the hash matter, so the product is cut to those bits.
   assign home_slot   = ssht_pkg::SLOT_W'(req_site_key)
                        ^ ssht_pkg::SLOT_W'(req_line_number * ssht_pkg::HASH_MUL);
   assign req_ignored = (req_site_key == '0) || (req_size_bytes == '0)
                        || ((req_func != ssht_pkg::FUNC_ALLOC) && (req_func != ssht_pkg::FUNC_GROW)
                            && (req_func != ssht_pkg::FUNC_FREE));
   assign is_free     = (func_ff == ssht_pkg::FUNC_FREE);
   assign probe_empty = !rd_valid_ff;
   assign probe_hit   = rd_valid_ff && (rd_data_ff.key == key_ff) && (rd_data_ff.line == line_ff);

   always_comb begin
      probe_entry      = '0;
      probe_entry.key  = key_ff;
      probe_entry.line = line_ff;
      if (rd_valid_ff) begin
         probe_entry = rd_data_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      probe_cnt_in = probe_cnt_ff;
      entry_in     = entry_ff;
      new_in       = new_ff;
      overflow_in  = overflow_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      line_in      = line_ff;
      size_in      = size_ff;
      rsp_in       = rsp_ff;
      rsp_in.strobe = 1'b0;
      mem_we       = 1'b0;
      alu_op       = ssht_pkg::ALU_ADD_SAT;
      alu_a        = entry_ff.allocated;
      alu_b        = size_ff;

      unique case (state_ff)
         ssht_pkg::ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               key_in  = req_site_key;
               line_in = req_line_number;
               size_in = req_size_bytes;
               if (req_ignored) begin
                  rsp_in          = '0;
                  rsp_in.strobe   = 1'b1;
                  rsp_in.status   = ssht_pkg::STAT_IGNORED;
                  rsp_in.overflow = overflow_ff;
               end else begin
                  slot_in      = home_slot;
                  probe_cnt_in = '0;
                  state_in     = ssht_pkg::ST_READ;
               end
            end
         end
         ssht_pkg::ST_READ: begin
            state_in = ssht_pkg::ST_PROBE;
         end
         ssht_pkg::ST_PROBE: begin
            if (probe_hit || probe_empty) begin
               entry_in = probe_entry;
               new_in   = probe_empty;
               state_in = ssht_pkg::ST_ACCUM;
            end else if (probe_cnt_ff == LAST_PROBE) begin
               overflow_in     = 1'b1;
               rsp_in          = '0;
               rsp_in.strobe   = 1'b1;
               rsp_in.status   = ssht_pkg::STAT_FULL;
               rsp_in.overflow = 1'b1;
               state_in        = ssht_pkg::ST_IDLE;
            end else begin
               // The slot counter wraps by itself since the table size is a power of two.
               slot_in      = slot_ff + ssht_pkg::SLOT_W'(1);
               probe_cnt_in = probe_cnt_ff + ssht_pkg::SLOT_W'(1);
               state_in     = ssht_pkg::ST_READ;
            end
         end
         ssht_pkg::ST_ACCUM: begin
            if (is_free) begin
               alu_a           = entry_ff.freed;
               entry_in.freed  = alu_y;
               entry_in.frees  = ssht_pkg::inc_sat(entry_ff.frees);
            end else begin
               entry_in.allocated = alu_y;
               if (func_ff == ssht_pkg::FUNC_GROW) begin
                  entry_in.grows = ssht_pkg::inc_sat(entry_ff.grows);
               end else begin
                  entry_in.allocs = ssht_pkg::inc_sat(entry_ff.allocs);
               end
            end
            state_in = ssht_pkg::ST_LIVE;
         end
         ssht_pkg::ST_LIVE: begin
            alu_a         = entry_ff.live;
            alu_op        = is_free ? ssht_pkg::ALU_SUB_FLOOR : ssht_pkg::ALU_ADD_SAT;
            entry_in.live = alu_y;
            state_in      = is_free ? ssht_pkg::ST_WRITE : ssht_pkg::ST_PEAK;
         end
         ssht_pkg::ST_PEAK: begin
            alu_op        = ssht_pkg::ALU_MAX;
            alu_a         = entry_ff.peak;
            alu_b         = entry_ff.live;
            entry_in.peak = alu_y;
            state_in      = ssht_pkg::ST_WRITE;
         end
         ssht_pkg::ST_WRITE: begin
            mem_we           = 1'b1;
            rsp_in.strobe    = 1'b1;
            rsp_in.status    = new_ff ? ssht_pkg::STAT_NEW : ssht_pkg::STAT_HIT;
            rsp_in.slot      = ssht_pkg::slot_out(slot_ff);
            rsp_in.allocated = entry_ff.allocated;
            rsp_in.freed     = entry_ff.freed;
            rsp_in.live      = entry_ff.live;
            rsp_in.peak      = entry_ff.peak;
            rsp_in.allocs    = entry_ff.allocs;
            rsp_in.grows     = entry_ff.grows;
            rsp_in.frees     = entry_ff.frees;
            rsp_in.overflow  = overflow_ff;
            state_in         = ssht_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssht_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ssht_pkg::ST_IDLE;
         overflow_ff   <= 1'b0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
         rsp_ff      <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      probe_cnt_ff <= probe_cnt_in;
      entry_ff     <= entry_in;
      new_ff       <= new_in;
      func_ff      <= func_in;
      key_ff       <= key_in;
      line_ff      <= line_in;
      size_ff      <= size_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[slot_ff] <= entry_ff;
      end
      rd_data_ff  <= table_mem[slot_ff];
      rd_valid_ff <= valid_ff[slot_ff];
   end

   assign busy                     = (state_ff != ssht_pkg::ST_IDLE);
   assign rsp_strobe               = rsp_ff.strobe;
   assign rsp_status               = rsp_ff.status;
   assign rsp_slot_index           = rsp_ff.slot;
   assign rsp_site_total_allocated = rsp_ff.allocated;
   assign rsp_site_total_freed     = rsp_ff.freed;
   assign rsp_site_current_usage   = rsp_ff.live;
   assign rsp_site_peak_usage      = rsp_ff.peak;
   assign rsp_site_alloc_count     = rsp_ff.allocs;
   assign rsp_site_grow_count      = rsp_ff.grows;
   assign rsp_site_free_count      = rsp_ff.frees;
   assign rsp_overflow_seen        = rsp_ff.overflow;

   `SSHT_ASSERT(a_overflow_sticky, (overflow_ff |=> overflow_ff), "overflow flag cleared outside reset")
   `SSHT_ASSERT(a_done_responds, (!$past(reset) && $fell(busy) |-> rsp_strobe), "request finished without a response")
   `SSHT_ASSERT(a_no_slot_data, (rsp_strobe && (rsp_status == ssht_pkg::STAT_FULL || rsp_status == ssht_pkg::STAT_IGNORED) |-> rsp_slot_index == '0 && rsp_site_current_usage == '0), "slot data on a response without a slot")
   `SSHT_ASSERT(a_peak_covers_live, (rsp_strobe && (rsp_status == ssht_pkg::STAT_HIT || rsp_status == ssht_pkg::STAT_NEW) |-> rsp_site_peak_usage >= rsp_site_current_usage), "peak usage below current usage")
   `SSHT_ASSERT_ALWAYS(a_full_flags_overflow, (rsp_strobe && rsp_status == ssht_pkg::STAT_FULL |-> rsp_overflow_seen), "table full without overflow flag")

endmodule

[bench/site_stats_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the site statistics hash table bench: a slot-table predictor and the queue
// of expected results, with field-by-field checking. Depends on ssht_pkg from the RTL.
package site_stats_scoreboard_pkg;

   localparam logic [ssht_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      ssht_pkg::status_type            status;
      logic [ssht_pkg::SLOT_OUT_W-1:0] slot;
      logic [ssht_pkg::BYTES_W-1:0]    allocated;
      logic [ssht_pkg::BYTES_W-1:0]    freed;
      logic [ssht_pkg::BYTES_W-1:0]    live;
      logic [ssht_pkg::BYTES_W-1:0]    peak;
      logic [ssht_pkg::COUNT_W-1:0]    allocs;
      logic [ssht_pkg::COUNT_W-1:0]    grows;
      logic [ssht_pkg::COUNT_W-1:0]    frees;
      logic                            overflow;
   } site_result_type;

   class site_stats_scoreboard;
      logic [ssht_pkg::KEY_W-1:0]   slot_key       [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::LINE_W-1:0]  slot_line      [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::BYTES_W-1:0] slot_allocated [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::BYTES_W-1:0] slot_freed     [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::BYTES_W-1:0] slot_live      [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::BYTES_W-1:0] slot_peak      [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::COUNT_W-1:0] slot_allocs    [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::COUNT_W-1:0] slot_grows     [ssht_pkg::TABLE_ENTRIES];
      logic [ssht_pkg::COUNT_W-1:0] slot_frees     [ssht_pkg::TABLE_ENTRIES];
      logic                         overflow_flag;
      site_result_type              expected_results [$];
      int                           mismatches;
      int                           results_checked;
      int                           status_count [4];

      function new();
         foreach (slot_key[i]) begin
            slot_key[i]       = '0;
            slot_line[i]      = '0;
            slot_allocated[i] = '0;
            slot_freed[i]     = '0;
            slot_live[i]      = '0;
            slot_peak[i]      = '0;
            slot_allocs[i]    = '0;
            slot_grows[i]     = '0;
            slot_frees[i]     = '0;
         end
         foreach (status_count[i]) status_count[i] = 0;
         overflow_flag   = 1'b0;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      function logic [ssht_pkg::BYTES_W-1:0] add_bytes(logic [ssht_pkg::BYTES_W-1:0] a,
                                                       logic [ssht_pkg::BYTES_W-1:0] b);
         logic [ssht_pkg::BYTES_W:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[ssht_pkg::BYTES_W] ? {ssht_pkg::BYTES_W{1'b1}}
                                       : sum[ssht_pkg::BYTES_W-1:0];
      endfunction

      function logic [ssht_pkg::COUNT_W-1:0] bump_count(logic [ssht_pkg::COUNT_W-1:0] count);
         return (count == {ssht_pkg::COUNT_W{1'b1}}) ? count
                                                     : count + ssht_pkg::COUNT_W'(1);
      endfunction

      // Walks the table from the home slot exactly as the block must, updates the site and
      // queues the result this request should produce.
      function void note_request(logic [ssht_pkg::FUNC_W-1:0] func,
                                 logic [ssht_pkg::KEY_W-1:0] key,
                                 logic [ssht_pkg::LINE_W-1:0] line,
                                 logic [ssht_pkg::BYTES_W-1:0] size);
         site_result_type res;
         logic [63:0]     mixed;
         int              slot;
         int              probes;
         bit              found;
         res        = '0;
         res.status = ssht_pkg::STAT_IGNORED;
         slot       = 0;
         found      = 1'b0;
         if (key != '0 && size != '0 && func != FUNC_UNUSED) begin
            mixed = 64'(key) ^ (64'(line) * 64'(ssht_pkg::HASH_MUL));
            slot  = int'(mixed % 64'(ssht_pkg::TABLE_ENTRIES));
            for (probes = 0; probes < ssht_pkg::TABLE_ENTRIES && !found; probes++) begin
               if (slot_key[slot] == key && slot_line[slot] == line) begin
                  res.status = ssht_pkg::STAT_HIT;
                  found      = 1'b1;
               end else if (slot_key[slot] == '0) begin
                  slot_key[slot]  = key;
                  slot_line[slot] = line;
                  res.status      = ssht_pkg::STAT_NEW;
                  found           = 1'b1;
               end else begin
                  slot = (slot + 1) % ssht_pkg::TABLE_ENTRIES;
               end
            end
            if (!found) begin
               overflow_flag = 1'b1;
               res.status    = ssht_pkg::STAT_FULL;
            end else if (func == ssht_pkg::FUNC_FREE) begin
               slot_freed[slot] = add_bytes(slot_freed[slot], size);
               slot_live[slot]  = (slot_live[slot] < size) ? '0 : slot_live[slot] - size;
               slot_frees[slot] = bump_count(slot_frees[slot]);
            end else begin
               slot_allocated[slot] = add_bytes(slot_allocated[slot], size);
               slot_live[slot]      = add_bytes(slot_live[slot], size);
               if (slot_live[slot] > slot_peak[slot]) slot_peak[slot] = slot_live[slot];
               if (func == ssht_pkg::FUNC_GROW) slot_grows[slot] = bump_count(slot_grows[slot]);
               else slot_allocs[slot] = bump_count(slot_allocs[slot]);
            end
         end
         if (found) begin
            res.slot      = ssht_pkg::SLOT_OUT_W'(slot);
            res.allocated = slot_allocated[slot];
            res.freed     = slot_freed[slot];
            res.live      = slot_live[slot];
            res.peak      = slot_peak[slot];
            res.allocs    = slot_allocs[slot];
            res.grows     = slot_grows[slot];
            res.frees     = slot_frees[slot];
         end
         res.overflow = overflow_flag;
         status_count[int'(res.status)]++;
         expected_results.push_back(res);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d, %s: expected 0x%0h, got 0x%0h",
                        results_checked, name, want, got);
         end
      endfunction

      function void check_result(site_result_type seen);
         site_result_type want;
         results_checked++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d arrived with no request outstanding (status %0d)",
                        results_checked, seen.status);
            return;
         end
         want = expected_results.pop_front();
         compare_field("status", 64'(want.status), 64'(seen.status));
         compare_field("slot_index", 64'(want.slot), 64'(seen.slot));
         compare_field("total_allocated", 64'(want.allocated), 64'(seen.allocated));
         compare_field("total_freed", 64'(want.freed), 64'(seen.freed));
         compare_field("current_usage", 64'(want.live), 64'(seen.live));
         compare_field("peak_usage", 64'(want.peak), 64'(seen.peak));
         compare_field("alloc_count", 64'(want.allocs), 64'(seen.allocs));
         compare_field("grow_count", 64'(want.grows), 64'(seen.grows));
         compare_field("free_count", 64'(want.frees), 64'(seen.frees));
         compare_field("overflow_seen", 64'(want.overflow), 64'(seen.overflow));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function int occupied_slots();
         int used;
         used = 0;
         foreach (slot_key[i]) if (slot_key[i] != '0) used++;
         return used;
      endfunction

      function int failures();
         return mismatches + expected_results.size();
      endfunction
   endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Top of the bench for site_stats_hash_table: drives event requests with random gaps and
// checks each result against site_stats_scoreboard_pkg. Needs ssht_pkg and the RTL.
module tb_top;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int POOL_SITES    = 48;
   localparam int RANDOM_EVENTS = 1400;
   localparam int FULL_EVENTS   = 80;
   localparam int DRAIN_CYCLES  = 2 * ssht_pkg::TABLE_ENTRIES + 8;
   localparam logic [ssht_pkg::BYTES_W-1:0] MAX_BYTES = '1;
   localparam logic [ssht_pkg::KEY_W-1:0]   MAX_KEY   = '1;
   localparam logic [ssht_pkg::LINE_W-1:0]  MAX_LINE  = '1;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [ssht_pkg::FUNC_W-1:0]     req_func = '0;
   logic [ssht_pkg::KEY_W-1:0]      req_site_key = '0;
   logic [ssht_pkg::LINE_W-1:0]     req_line_number = '0;
   logic [ssht_pkg::BYTES_W-1:0]    req_size_bytes = '0;
   logic                            rsp_strobe;
   logic [1:0]                      rsp_status;
   logic [ssht_pkg::SLOT_OUT_W-1:0] rsp_slot_index;
   logic [ssht_pkg::BYTES_W-1:0]    rsp_site_total_allocated;
   logic [ssht_pkg::BYTES_W-1:0]    rsp_site_total_freed;
   logic [ssht_pkg::BYTES_W-1:0]    rsp_site_current_usage;
   logic [ssht_pkg::BYTES_W-1:0]    rsp_site_peak_usage;
   logic [ssht_pkg::COUNT_W-1:0]    rsp_site_alloc_count;
   logic [ssht_pkg::COUNT_W-1:0]    rsp_site_grow_count;
   logic [ssht_pkg::COUNT_W-1:0]    rsp_site_free_count;
   logic                            rsp_overflow_seen;

   site_stats_scoreboard_pkg::site_stats_scoreboard sb;
   int                           cycle_count = 0;
   int                           requests_sent = 0;
   int                           counted_events = 0;
   int                           burst_left = 0;
   logic [ssht_pkg::KEY_W-1:0]   pool_key  [POOL_SITES];
   logic [ssht_pkg::LINE_W-1:0]  pool_line [POOL_SITES];

   site_stats_hash_table dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  sb.pending());
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      site_stats_scoreboard_pkg::site_result_type seen;
      if (!reset && rsp_strobe) begin
         seen.status    = ssht_pkg::status_type'(rsp_status);
         seen.slot      = rsp_slot_index;
         seen.allocated = rsp_site_total_allocated;
         seen.freed     = rsp_site_total_freed;
         seen.live      = rsp_site_current_usage;
         seen.peak      = rsp_site_peak_usage;
         seen.allocs    = rsp_site_alloc_count;
         seen.grows     = rsp_site_grow_count;
         seen.frees     = rsp_site_free_count;
         seen.overflow  = rsp_overflow_seen;
         sb.check_result(seen);
      end
   end

   function automatic logic [ssht_pkg::BYTES_W-1:0] random_size();
      int                           pick;
      logic [ssht_pkg::BYTES_W-1:0] size;
      pick = $urandom_range(0, 99);
      if (pick < 60) size = ssht_pkg::BYTES_W'($urandom_range(1, 4096));
      else if (pick < 90) size = ssht_pkg::BYTES_W'({$urandom, $urandom});
      else if (pick < 95) size = MAX_BYTES - ssht_pkg::BYTES_W'($urandom_range(0, 3));
      else size = ssht_pkg::BYTES_W'(1) << $urandom_range(0, ssht_pkg::BYTES_W - 1);
      if (size == '0) size = ssht_pkg::BYTES_W'(1);
      return size;
   endfunction

   function automatic logic [ssht_pkg::KEY_W-1:0] random_key();
      logic [ssht_pkg::KEY_W-1:0] key;
      key = ssht_pkg::KEY_W'({$urandom, $urandom});
      if (key == '0) key = ssht_pkg::KEY_W'(1);
      return key;
   endfunction

   // Picks the low key bits so that the site lands on the given home slot.
   function automatic logic [ssht_pkg::KEY_W-1:0] key_for_home(int home,
                                                               logic [ssht_pkg::LINE_W-1:0] line);
      logic [ssht_pkg::KEY_W-1:0] key;
      logic [63:0]                product;
      key     = random_key();
      product = 64'(line) * 64'(ssht_pkg::HASH_MUL);
      key[ssht_pkg::SLOT_W-1:0] = ssht_pkg::SLOT_W'(home) ^ product[ssht_pkg::SLOT_W-1:0];
      if (key == '0) key[ssht_pkg::KEY_W-1] = 1'b1;
      return key;
   endfunction

   function automatic logic [ssht_pkg::FUNC_W-1:0] random_func();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return ssht_pkg::FUNC_ALLOC;
      else if (pick < 65) return ssht_pkg::FUNC_GROW;
      else return ssht_pkg::FUNC_FREE;
   endfunction

   task automatic pause_after_request();
      int gap;
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
         end else if (pick < 40) gap = 0;
         else if (pick < 85) gap = $urandom_range(1, 3);
         else if (pick < 97) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         // Junk on the request ports while start is low must not reach the table.
         start           <= 1'b0;
         req_func        <= ssht_pkg::FUNC_W'($urandom);
         req_site_key    <= random_key();
         req_line_number <= $urandom;
         req_size_bytes  <= random_size();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_request(logic [ssht_pkg::FUNC_W-1:0] func,
                               logic [ssht_pkg::KEY_W-1:0] key,
                               logic [ssht_pkg::LINE_W-1:0] line,
                               logic [ssht_pkg::BYTES_W-1:0] size);
      start           <= 1'b1;
      req_func        <= func;
      req_site_key    <= key;
      req_line_number <= line;
      req_size_bytes  <= size;
      do @(posedge clock); while (busy);
      sb.note_request(func, key, line, size);
      requests_sent++;
      if (key != '0 && size != '0 && func != site_stats_scoreboard_pkg::FUNC_UNUSED)
         counted_events++;
      pause_after_request();
   endtask

   task automatic send_pool_event();
      int idx;
      idx = $urandom_range(0, POOL_SITES - 1);
      send_request(random_func(), pool_key[idx], pool_line[idx], random_size());
   endtask

   task automatic send_noise();
      int idx;
      idx = $urandom_range(0, POOL_SITES - 1);
      case ($urandom_range(0, 3))
         0: send_request(ssht_pkg::FUNC_W'($urandom), '0, $urandom, random_size());
         1: send_request(ssht_pkg::FUNC_W'($urandom), pool_key[idx], pool_line[idx], '0);
         2: send_request(site_stats_scoreboard_pkg::FUNC_UNUSED, pool_key[idx], pool_line[idx],
                         random_size());
         default: send_request(ssht_pkg::FUNC_W'($urandom), random_key(), $urandom,
                               random_size());
      endcase
   endtask

   initial begin
      logic [ssht_pkg::KEY_W-1:0] key_d;
      logic [ssht_pkg::KEY_W-1:0] key_e;
      logic [ssht_pkg::KEY_W-1:0] key_f;
      sb = new();
      // Site pool: clusters near the top of the table force wrap-around probing, another
      // cluster forces long chains, and some sites share a key with a different line.
      for (int i = 0; i < POOL_SITES; i++) begin
         pool_line[i] = (i % 3 == 0) ? ssht_pkg::LINE_W'($urandom_range(1, 2000))
                                     : ssht_pkg::LINE_W'($urandom);
         if (i < 8)
            pool_key[i] = key_for_home(ssht_pkg::TABLE_ENTRIES - 1 - (i % 2), pool_line[i]);
         else if (i < 16) pool_key[i] = key_for_home(17, pool_line[i]);
         else if (i % 5 == 0) pool_key[i] = pool_key[i - 1];
         else pool_key[i] = random_key();
      end
      key_d = key_for_home(ssht_pkg::TABLE_ENTRIES - 1, 32'd7);
      key_e = key_for_home(ssht_pkg::TABLE_ENTRIES - 1, 32'd9);
      key_f = key_for_home(ssht_pkg::TABLE_ENTRIES - 1, 32'd11);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored requests, byte saturation, free floor, new sites via every kind,
      // extreme keys and lines, and collisions on the last slot that wrap to the first.
      send_request(ssht_pkg::FUNC_ALLOC, '0, 32'd5, 48'd100);
      send_request(ssht_pkg::FUNC_ALLOC, 48'd1, '0, '0);
      send_request(site_stats_scoreboard_pkg::FUNC_UNUSED, 48'd1, '0, 48'd100);
      send_request(ssht_pkg::FUNC_ALLOC, 48'd1, '0, MAX_BYTES);
      send_request(ssht_pkg::FUNC_ALLOC, 48'd1, '0, MAX_BYTES);
      send_request(ssht_pkg::FUNC_GROW, 48'd1, '0, 48'd1);
      send_request(ssht_pkg::FUNC_FREE, 48'd1, '0, 48'd1);
      send_request(ssht_pkg::FUNC_FREE, 48'd1, '0, MAX_BYTES);
      send_request(ssht_pkg::FUNC_FREE, 48'd1, '0, 48'd5);
      send_request(ssht_pkg::FUNC_ALLOC, MAX_KEY, MAX_LINE, 48'd1);
      send_request(ssht_pkg::FUNC_GROW, MAX_KEY, '0, 48'd2);
      send_request(ssht_pkg::FUNC_FREE, 48'h8000_0000_0000, 32'h8000_0000, 48'd3);
      send_request(ssht_pkg::FUNC_ALLOC, key_d, 32'd7, 48'd10);
      send_request(ssht_pkg::FUNC_ALLOC, key_e, 32'd9, 48'd20);
      send_request(ssht_pkg::FUNC_ALLOC, key_f, 32'd11, 48'd30);
      send_request(ssht_pkg::FUNC_FREE, key_e, 32'd9, 48'd25);
      send_request(ssht_pkg::FUNC_GROW, key_d, 32'd7, 48'd5);
      send_request(site_stats_scoreboard_pkg::FUNC_UNUSED, '0, '0, '0);
      send_request(ssht_pkg::FUNC_ALLOC, 48'd1, '0, MAX_BYTES);

      // Mostly traffic on known sites, with noise and the odd brand-new site.
      while (counted_events < RANDOM_EVENTS) begin
         if ($urandom_range(0, 99) < 85) send_pool_event();
         else send_noise();
      end

      // Fill every slot, then keep hitting a full table.
      while (sb.occupied_slots() < ssht_pkg::TABLE_ENTRIES) begin
         if ($urandom_range(0, 4) == 0) send_pool_event();
         else send_request(random_func(), random_key(), $urandom, random_size());
      end
      repeat (FULL_EVENTS) begin
         case ($urandom_range(0, 4))
            0, 1: send_request(random_func(), random_key(), $urandom, random_size());
            2, 3: send_pool_event();
            default: send_noise();
         endcase
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d ignored kinds), %0d results checked.",
               requests_sent, requests_sent - counted_events, sb.results_checked);
      $display("Statuses: %0d updates, %0d new sites, %0d table full, %0d ignored.",
               sb.status_count[int'(ssht_pkg::STAT_HIT)],
               sb.status_count[int'(ssht_pkg::STAT_NEW)],
               sb.status_count[int'(ssht_pkg::STAT_FULL)],
               sb.status_count[int'(ssht_pkg::STAT_IGNORED)]);
      if (sb.failures() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
